FILE: rtl/iipc_pkg.sv
// Package for the integer interval point counter: widths, relation codes
// and the command struct passed from the control logic to the bound unit.
// No dependencies.
`timescale 1ns / 1ps

package iipc_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int COUNT_WIDTH   = 34;
  localparam int WL_WIDTH      = 6;
  localparam int WL_MAX        = 32;
  localparam int REL_WIDTH     = 3;

  // Bounds must hold a quotient of magnitude 2^(OPERAND_WIDTH-1) shifted by
  // one, and the initial range of a 32-bit word.
  localparam int BOUND_WIDTH = ((OPERAND_WIDTH > WL_MAX) ? OPERAND_WIDTH : WL_MAX) + 2;

  localparam int DIV_CNT_WIDTH = $clog2(OPERAND_WIDTH + 1);

  localparam int S_TDATA_WIDTH = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_WIDTH = ((COUNT_WIDTH + 7) / 8) * 8;
  localparam int S_TUSER_WIDTH = REL_WIDTH + 1;

  localparam logic [REL_WIDTH-1:0] REL_EQ = 3'd0;
  localparam logic [REL_WIDTH-1:0] REL_LE = 3'd1;
  localparam logic [REL_WIDTH-1:0] REL_LT = 3'd2;
  localparam logic [REL_WIDTH-1:0] REL_GT = 3'd3;
  localparam logic [REL_WIDTH-1:0] REL_GE = 3'd4;

  typedef struct packed {
    logic                     apply;
    logic                     set_lo;
    logic                     set_up;
    logic                     lo_ceil;
    logic                     up_floor;
    logic                     neg;
    logic                     rem_nz;
    logic [OPERAND_WIDTH-1:0] quotient;
  } bnd_cmd_t;

  typedef struct packed {
    logic                     done;
    logic                     rem_nz;
    logic [OPERAND_WIDTH-1:0] quotient;
  } div_res_t;

endpackage

FILE: rtl/iipc_div.sv
// Radix-2 restoring divider for operand magnitudes, one quotient bit per cycle.
// Depends on iipc_pkg.
`timescale 1ns / 1ps

module iipc_div import iipc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] dividend,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output div_res_t                 res
);

  logic                     busy;
  logic                     done;
  logic [DIV_CNT_WIDTH-1:0] cnt;
  logic [OPERAND_WIDTH-1:0] rem;
  logic [OPERAND_WIDTH-1:0] quo;
  logic [OPERAND_WIDTH-1:0] dvs;
  logic [OPERAND_WIDTH:0]   shifted;
  logic [OPERAND_WIDTH+1:0] trial;

  assign shifted = {rem, quo[OPERAND_WIDTH-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_WIDTH'(OPERAND_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[OPERAND_WIDTH+1]) begin
        rem <= trial[OPERAND_WIDTH-1:0];
        quo <= {quo[OPERAND_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[OPERAND_WIDTH-1:0];
        quo <= {quo[OPERAND_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign res.done     = done;
  assign res.rem_nz   = |rem;
  assign res.quotient = quo;

endmodule

FILE: rtl/iipc_bounds.sv
// Lower and upper bound registers, their tightening from a quotient, and the
// point count of the current interval. Depends on iipc_pkg.
`timescale 1ns / 1ps

module iipc_bounds import iipc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [WL_WIDTH-1:0]    load_wl,
  input  bnd_cmd_t               cmd,
  output logic [COUNT_WIDTH-1:0] count,
  output logic                   unb
);

  logic signed [BOUND_WIDTH-1:0] lower_bound;
  logic signed [BOUND_WIDTH-1:0] upper_bound;
  logic                          lower_known;
  logic                          upper_known;

  logic [WL_WIDTH-1:0]           wl_c;
  logic [BOUND_WIDTH-1:0]        half;
  logic signed [BOUND_WIDTH-1:0] init_lo;
  logic signed [BOUND_WIDTH-1:0] init_up;

  logic [BOUND_WIDTH-1:0]        qext;
  logic [BOUND_WIDTH-1:0]        base;
  logic signed [2:0]             lo_off;
  logic signed [2:0]             up_off;
  logic signed [BOUND_WIDTH-1:0] lo_val;
  logic signed [BOUND_WIDTH-1:0] up_val;

  logic signed [BOUND_WIDTH:0]   diff;
  logic [BOUND_WIDTH+1:0]        full;

  assign wl_c    = (load_wl > WL_WIDTH'(WL_MAX)) ? WL_WIDTH'(WL_MAX) : load_wl;
  assign half    = BOUND_WIDTH'(1) << (wl_c - 1'b1);
  assign init_lo = -$signed(half);
  assign init_up = $signed(half - 1'b1);

  assign qext = BOUND_WIDTH'(cmd.quotient);
  assign base = cmd.neg ? ~qext : qext;

  always_comb begin
    if (cmd.lo_ceil) begin
      lo_off = cmd.neg ? 3'sd1 : (cmd.rem_nz ? 3'sd1 : 3'sd0);
    end else begin
      lo_off = cmd.neg ? (cmd.rem_nz ? 3'sd1 : 3'sd2) : 3'sd1;
    end
    if (cmd.up_floor) begin
      up_off = cmd.neg ? (cmd.rem_nz ? 3'sd0 : 3'sd1) : 3'sd0;
    end else begin
      up_off = cmd.neg ? 3'sd0 : (cmd.rem_nz ? 3'sd0 : -3'sd1);
    end
  end

  assign lo_val = $signed(base) + $signed({{(BOUND_WIDTH-3){lo_off[2]}}, lo_off});
  assign up_val = $signed(base) + $signed({{(BOUND_WIDTH-3){up_off[2]}}, up_off});

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= -$signed(BOUND_WIDTH'(1) << (WL_MAX - 1));
      upper_bound <= $signed((BOUND_WIDTH'(1) << (WL_MAX - 1)) - 1'b1);
      lower_known <= 1'b1;
      upper_known <= 1'b1;
    end else if (load) begin
      if (wl_c == '0) begin
        lower_bound <= '0;
        upper_bound <= '0;
        lower_known <= 1'b0;
        upper_known <= 1'b0;
      end else begin
        lower_bound <= init_lo;
        upper_bound <= init_up;
        lower_known <= 1'b1;
        upper_known <= 1'b1;
      end
    end else if (cmd.apply) begin
      if (cmd.set_lo && (!lower_known || lo_val > lower_bound)) begin
        lower_bound <= lo_val;
        lower_known <= 1'b1;
      end
      if (cmd.set_up && (!upper_known || up_val < upper_bound)) begin
        upper_bound <= up_val;
        upper_known <= 1'b1;
      end
    end
  end

  assign diff = {upper_bound[BOUND_WIDTH-1], upper_bound}
              - {lower_bound[BOUND_WIDTH-1], lower_bound};
  assign full = {1'b0, diff} + 1'b1;

  always_comb begin
    unb   = 1'b0;
    count = '0;
    if (!lower_known || !upper_known) begin
      unb = 1'b1;
    end else if (!diff[BOUND_WIDTH]) begin
      if (|full[BOUND_WIDTH+1:COUNT_WIDTH]) begin
        count = '1;
      end else begin
        count = full[COUNT_WIDTH-1:0];
      end
    end
  end

endmodule

FILE: rtl/integer_interval_point_counter.sv
// Top level of the integer interval point counter: stream ports, control
// sequencer and result register. Depends on iipc_pkg, iipc_div, iipc_bounds.
//
// Channel  Direction  Transaction carries
// s_*      in         one constraint: coefficient, constant, relation, asserted, last
// m_*      out        one result per set: point_count, unbounded
// cfg_*    in         word_length
//
// A constraint with a nonzero coefficient and a valid relation runs through
// the bit-serial divider in ST_DIV before its bounds are tightened; other
// constraints are taken in ST_IDLE alone. A last constraint then passes ST_COUNT
// to form the count. Reset sets word_length to 32 and loads its bounds.
// A new constraint is accepted while a result waits; a set finishes only once
// the result register is free.
`timescale 1ns / 1ps

module integer_interval_point_counter import iipc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // s_tdata: coefficient, constant
  input  logic [S_TDATA_WIDTH-1:0] s_tdata,
  // s_tuser: relation, asserted
  input  logic [S_TUSER_WIDTH-1:0] s_tuser,
  input  logic                     s_tlast,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // m_tdata: point_count, zero fill
  output logic [M_TDATA_WIDTH-1:0] m_tdata,
  // m_tuser: unbounded
  output logic [0:0]               m_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [WL_WIDTH-1:0]      cfg_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [WL_WIDTH-1:0]      word_length;

  logic signed [OPERAND_WIDTH-1:0] coefficient;
  logic signed [OPERAND_WIDTH-1:0] constant;
  logic [REL_WIDTH-1:0]     relation;
  logic                     asserted;
  logic [OPERAND_WIDTH-1:0] a_mag;
  logic [OPERAND_WIDTH-1:0] b_mag;
  logic [REL_WIDTH-1:0]     rel_flip;
  logic [REL_WIDTH-1:0]     rel_eff;
  logic                     s_acc;
  logic                     needs_div;
  logic                     cfg_acc;
  logic                     out_free;
  logic                     finish;

  logic                     last_q;
  logic                     set_lo;
  logic                     set_up;
  logic                     lo_ceil;
  logic                     up_floor;
  logic                     neg;

  div_res_t                 div_res;
  bnd_cmd_t                 cmd;
  logic [COUNT_WIDTH-1:0]   count;
  logic                     unb;

  assign coefficient = s_tdata[OPERAND_WIDTH-1:0];
  assign constant    = s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
  assign relation    = s_tuser[REL_WIDTH-1:0];
  assign asserted    = s_tuser[REL_WIDTH];

  assign a_mag = coefficient[OPERAND_WIDTH-1] ? (~coefficient + 1'b1) : coefficient;
  assign b_mag = constant[OPERAND_WIDTH-1] ? (~constant + 1'b1) : constant;

  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign needs_div = (coefficient != '0) && (relation inside {[REL_EQ:REL_GE]});
  assign out_free  = !m_tvalid || m_tready;
  assign finish    = (state == ST_COUNT) && out_free;

  always_comb begin
    rel_flip = coefficient[OPERAND_WIDTH-1] ? (REL_WIDTH'(5) - relation) : relation;
    rel_eff  = rel_flip;
    if (!asserted) begin
      case (rel_flip)
        REL_LE:  rel_eff = REL_GT;
        REL_LT:  rel_eff = REL_GE;
        REL_GT:  rel_eff = REL_LE;
        REL_GE:  rel_eff = REL_LT;
        default: rel_eff = rel_flip;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (needs_div) begin
            state_next = ST_DIV;
          end else if (s_tlast) begin
            state_next = ST_COUNT;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_next = last_q ? ST_COUNT : ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      word_length <= WL_WIDTH'(WL_MAX);
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        word_length <= cfg_data;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      last_q <= s_tlast;
      neg    <= coefficient[OPERAND_WIDTH-1] ^ constant[OPERAND_WIDTH-1];
      if (relation == REL_EQ) begin
        set_lo   <= 1'b1;
        set_up   <= 1'b1;
        lo_ceil  <= 1'b1;
        up_floor <= 1'b1;
      end else begin
        set_lo   <= (rel_eff == REL_GT) || (rel_eff == REL_GE);
        set_up   <= (rel_eff == REL_LE) || (rel_eff == REL_LT);
        lo_ceil  <= (rel_eff == REL_GE);
        up_floor <= (rel_eff == REL_LE);
      end
    end
    if (finish) begin
      m_tdata    <= M_TDATA_WIDTH'(count);
      m_tuser[0] <= unb;
    end
  end

  iipc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (s_acc && needs_div),
    .dividend (b_mag),
    .divisor  (a_mag),
    .res      (div_res)
  );

  assign cmd.apply    = (state == ST_DIV) && div_res.done;
  assign cmd.set_lo   = set_lo;
  assign cmd.set_up   = set_up;
  assign cmd.lo_ceil  = lo_ceil;
  assign cmd.up_floor = up_floor;
  assign cmd.neg      = neg;
  assign cmd.rem_nz   = div_res.rem_nz;
  assign cmd.quotient = div_res.quotient;

  iipc_bounds u_bounds (
    .clk     (clk),
    .rst     (rst),
    .load    (cfg_acc || finish),
    .load_wl (cfg_acc ? cfg_data : word_length),
    .cmd     (cmd),
    .count   (count),
    .unb     (unb)
  );

endmodule

FILE: sim/integer_interval_point_counter_tb.sv
// Self-checking testbench for integer_interval_point_counter: drives constraint sets,
// predicts each interval count internally and compares every result it receives.
// Depends on iipc_pkg and the RTL of the block; needs no files.
`timescale 1ns / 1ps

module integer_interval_point_counter_tb;
  import iipc_pkg::*;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [REL_WIDTH-1:0] rel_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   unbounded;
  } tally_t;

  localparam rel_t REL_RSV5 = 3'd5;
  localparam rel_t REL_RSV6 = 3'd6;
  localparam rel_t REL_RSV7 = 3'd7;
  localparam operand_t OP_MIN = {1'b1, {(OPERAND_WIDTH - 1){1'b0}}};
  localparam operand_t OP_MAX = {1'b0, {(OPERAND_WIDTH - 1){1'b1}}};
  localparam longint COUNT_MAX = (longint'(1) << COUNT_WIDTH) - 1;
  localparam int SETTLE_CYCLES = OPERAND_WIDTH + 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 160;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
  logic [S_TUSER_WIDTH-1:0] s_tuser = '0;
  logic                     s_tlast = 1'b0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [M_TDATA_WIDTH-1:0] m_tdata;
  logic [0:0]               m_tuser;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [WL_WIDTH-1:0]      cfg_data = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;

  logic [WL_WIDTH-1:0] word_len;
  longint              lo_val;
  longint              hi_val;
  bit                  lo_set;
  bit                  hi_set;
  tally_t              tally_q[$];

  int          errors = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          hold_left = 0;
  longint      cycles = 0;

  integer_interval_point_counter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_data (cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver either serves a long hold-off or stalls at random.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40) begin
      $display("tb: mismatch in %s: got %0d, expected %0d", what, got, want);
    end
  endtask

  // Outputs are stable at the falling edge; a transaction seen here completes at the
  // next rising edge.
  always @(negedge clk) begin
    tally_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (tally_q.size() == 0) begin
        report_mismatch("unexpected result", longint'(m_tdata[COUNT_WIDTH-1:0]), 0);
      end else begin
        want = tally_q.pop_front();
        if (m_tdata[COUNT_WIDTH-1:0] !== want.count) begin
          report_mismatch("point_count", longint'(m_tdata[COUNT_WIDTH-1:0]),
                          longint'(want.count));
        end
        if (m_tuser[0] !== want.unbounded) begin
          report_mismatch("unbounded", longint'(m_tuser[0]), longint'(want.unbounded));
        end
      end
    end
  end

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    longint r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic longint ceil_quot(input longint n, input longint d);
    longint q;
    longint r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) == (d < 0))) q = q + 1;
    return q;
  endfunction

  task automatic reload_range();
    int wl;
    wl = (word_len > WL_MAX) ? WL_MAX : int'(word_len);
    if (wl == 0) begin
      lo_val = 0;
      hi_val = 0;
      lo_set = 1'b0;
      hi_set = 1'b0;
    end else begin
      lo_val = -(longint'(1) << (wl - 1));
      hi_val = (longint'(1) << (wl - 1)) - 1;
      lo_set = 1'b1;
      hi_set = 1'b1;
    end
  endtask

  task automatic raise_low(input longint v);
    if (!lo_set || v > lo_val) begin
      lo_val = v;
      lo_set = 1'b1;
    end
  endtask

  task automatic lower_high(input longint v);
    if (!hi_set || v < hi_val) begin
      hi_val = v;
      hi_set = 1'b1;
    end
  endtask

  task automatic tighten_interval(input operand_t coef, input operand_t cnst, input rel_t rel,
                                  input logic asrt, input logic lst);
    longint a;
    longint b;
    longint fq;
    longint cq;
    longint span;
    rel_t   r;
    tally_t t;
    a = coef;
    b = cnst;
    r = rel;
    if (a != 0 && r <= REL_GE) begin
      fq = floor_quot(b, a);
      cq = ceil_quot(b, a);
      if (r == REL_EQ) begin
        raise_low(cq);
        lower_high(fq);
      end else begin
        if (a < 0) begin
          case (r)
            REL_LE: r = REL_GE;
            REL_LT: r = REL_GT;
            REL_GT: r = REL_LT;
            default: r = REL_LE;
          endcase
        end
        if (!asrt) begin
          case (r)
            REL_LE: r = REL_GT;
            REL_LT: r = REL_GE;
            REL_GT: r = REL_LE;
            default: r = REL_LT;
          endcase
        end
        case (r)
          REL_LE: lower_high(fq);
          REL_LT: lower_high(cq - 1);
          REL_GT: raise_low(fq + 1);
          default: raise_low(cq);
        endcase
      end
    end
    if (lst) begin
      t.count = '0;
      t.unbounded = 1'b0;
      if (!lo_set || !hi_set) begin
        t.unbounded = 1'b1;
      end else if (hi_val >= lo_val) begin
        span = hi_val - lo_val + 1;
        if (span > COUNT_MAX) span = COUNT_MAX;
        t.count = COUNT_WIDTH'(span);
      end
      tally_q = {tally_q, t};
      reload_range();
    end
  endtask

  task automatic send_constraint(input operand_t coef, input operand_t cnst, input rel_t rel,
                                 input logic asrt, input logic lst);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tdata <= S_TDATA_WIDTH'({cnst, coef});
    s_tuser <= {asrt, rel};
    s_tlast <= lst;
    s_tvalid <= 1'b1;
    tighten_interval(coef, cnst, rel, asrt, lst);
    do @(negedge clk); while (s_tready !== 1'b1);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_word_length(input logic [WL_WIDTH-1:0] wl);
    wait_idle();
    cfg_data <= wl;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    cfg_valid <= 1'b0;
    word_len = wl;
    reload_range();
  endtask

  function automatic operand_t pick_operand();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return operand_t'(int'($urandom_range(20)) - 10);
    if (sel < 65) begin
      case ($urandom_range(4))
        0: return OP_MIN;
        1: return OP_MAX;
        2: return '1;
        3: return '0;
        default: return operand_t'(1);
      endcase
    end
    return operand_t'({$urandom, $urandom});
  endfunction

  task automatic test_directed_cases();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_word_length(6'd32);
    send_constraint(1, 5, REL_LE, 1'b1, 1'b1);
    send_constraint(0, 7, REL_LT, 1'b1, 1'b1);
    send_constraint(OP_MIN, OP_MAX, REL_GE, 1'b1, 1'b0);
    send_constraint(OP_MAX, OP_MIN, REL_LT, 1'b1, 1'b1);
    send_constraint(3, 3, REL_RSV5, 1'b1, 1'b0);
    send_constraint(3, 3, REL_RSV6, 1'b0, 1'b0);
    send_constraint(3, 3, REL_RSV7, 1'b1, 1'b1);
    send_constraint(3, 10, REL_EQ, 1'b0, 1'b1);
    send_constraint(2, 10, REL_EQ, 1'b1, 1'b1);
    send_constraint(-3, 7, REL_LT, 1'b0, 1'b0);
    send_constraint(4, -9, REL_GT, 1'b1, 1'b0);
    send_constraint(-5, -11, REL_GE, 1'b0, 1'b0);
    send_constraint(7, -10, REL_LE, 1'b0, 1'b1);
    send_constraint(-1, OP_MIN, REL_LE, 1'b1, 1'b1);
    write_word_length(6'd0);
    send_constraint(1, -10, REL_GE, 1'b1, 1'b1);
    send_constraint(1, OP_MIN, REL_GE, 1'b1, 1'b0);
    send_constraint(-1, OP_MIN, REL_GE, 1'b1, 1'b1);
    send_constraint(1, -10, REL_GT, 1'b1, 1'b0);
    send_constraint(1, 10, REL_LT, 1'b1, 1'b1);
    write_word_length(6'd63);
    send_constraint(-1, -1, REL_EQ, 1'b1, 1'b1);
    write_word_length(6'd1);
    send_constraint(OP_MAX, OP_MAX, REL_LE, 1'b0, 1'b1);
  endtask

  task automatic test_random_sets(input logic [WL_WIDTH-1:0] wl, input int idle_pct,
                                  input int stall_pct);
    int   sent;
    int   set_len;
    rel_t rel;
    write_word_length(wl);
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      set_len = $urandom_range(1, 5);
      for (int i = 0; i < set_len; i++) begin
        if ($urandom_range(9) == 0) rel = rel_t'($urandom_range(REL_RSV5, REL_RSV7));
        else rel = rel_t'($urandom_range(REL_EQ, REL_GE));
        send_constraint(pick_operand(), pick_operand(), rel, logic'($urandom_range(1)),
                        i == set_len - 1);
        sent++;
      end
    end
  endtask

  // Results pile up behind a stalled receiver until the input stalls as well.
  task automatic test_output_backpressure();
    wait_idle();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    @(negedge clk);
    hold_left = 600;
    @(posedge clk);
    for (int i = 0; i < 24; i++) begin
      send_constraint(pick_operand(), pick_operand(), rel_t'($urandom_range(REL_EQ, REL_GE)),
                      logic'($urandom_range(1)), 1'b1);
    end
  endtask

  initial begin
    word_len = 6'd32;
    reload_range();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_sets(6'd32, 0, 0);
    test_random_sets(6'd0, 59, 0);
    test_random_sets(6'd63, 0, 59);
    test_random_sets(6'd1, 14, 14);
    test_random_sets(6'd16, 0, 0);
    test_random_sets(6'd33, 59, 0);
    test_random_sets(WL_WIDTH'($urandom_range(2, 31)), 0, 59);
    test_random_sets(6'd8, 14, 14);
    test_output_backpressure();
    wait_idle();
    if (tally_q.size() != 0) report_mismatch("results still expected", tally_q.size(), 0);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/iipc_pkg.sv
rtl/iipc_div.sv
rtl/iipc_bounds.sv
rtl/integer_interval_point_counter.sv
sim/integer_interval_point_counter_tb.sv
